[rtl/core/mts_pkg.sv]
// Package for the minimum-tracking stack: command and status codes.
// No dependencies; imported by the stack core and its checker.
`default_nettype none

package mts_pkg;

	typedef logic [1:0] status_t;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	localparam status_t STATUS_OK         = 2'd0;
	localparam status_t STATUS_POP_EMPTY  = 2'd1;
	localparam status_t STATUS_PUSH_FULL  = 2'd2;

endpackage

`default_nettype wire

[rtl/core/min_tracking_stack.sv]
// Top level of the minimum-tracking stack: control, top-of-stack registers, counts.
// Depends on mts_pkg and two instances of mts_ram.
`default_nettype none

// A command is taken when start is high and busy is low; its result appears on
// min_value, is_empty and status for exactly one cycle with done high, and the
// receiver cannot hold it off. A push, and any ignored command, shows its result in
// the next cycle, and another command may be started at once. A successful pop
// first raises busy while both stores read the entries below the current tops
// through their registered read ports, and the result shows in the cycle after
// that. No clearing pass follows reset.
module min_tracking_stack #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         cmd,
	input  wire logic signed [DATA_WIDTH-1:0] value,
	output logic                              done,
	output logic signed [DATA_WIDTH-1:0]      min_value,
	output logic                              is_empty,
	output mts_pkg::status_t                  status
);

	import mts_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WAIT = 1'b1;

	logic                         state_q;
	logic [CW-1:0]                vcount_q;
	logic [CW-1:0]                mcount_q;
	logic signed [DATA_WIDTH-1:0] vtop_q;
	logic signed [DATA_WIDTH-1:0] mtop_q;
	logic                         done_q;
	logic signed [DATA_WIDTH-1:0] min_q;
	logic                         empty_q;
	status_t                      status_q;

	logic                  accept;
	logic                  full;
	logic                  vempty;
	logic                  mempty;
	logic                  min_push;
	logic                  min_pop;
	logic                  v_we;
	logic                  m_we;
	logic [CW-1:0]         vcount_pop;
	logic [CW-1:0]         mcount_pop;
	logic [CW-1:0]         v_rd;
	logic [CW-1:0]         m_rd;
	logic [DATA_WIDTH-1:0] v_rdata;
	logic [DATA_WIDTH-1:0] m_rdata;

	assign busy   = (state_q == ST_WAIT);
	assign accept = start && !busy;
	assign full   = (vcount_q == CW'(DEPTH));
	assign vempty = (vcount_q == '0);
	assign mempty = (mcount_q == '0);

	// A value equal to the current minimum goes onto the min store again.
	assign min_push = mempty || (value <= mtop_q);
	assign min_pop  = !mempty && (mtop_q == vtop_q);

	assign v_we = accept && (cmd == CMD_PUSH) && !full;
	assign m_we = v_we && min_push;

	assign vcount_pop = vcount_q - CW'(1);
	assign mcount_pop = mcount_q - CW'(min_pop);
	// Entries below the new tops; unused when the new count is zero.
	assign v_rd = vcount_pop - CW'(1);
	assign m_rd = mcount_pop - CW'(1);

	mts_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_value_ram (
		.clk  (clk),
		.we   (v_we),
		.waddr(vcount_q[AW-1:0]),
		.wdata(value),
		.raddr(v_rd[AW-1:0]),
		.rdata(v_rdata)
	);

	mts_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_min_ram (
		.clk  (clk),
		.we   (m_we),
		.waddr(mcount_q[AW-1:0]),
		.wdata(value),
		.raddr(m_rd[AW-1:0]),
		.rdata(m_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			vcount_q <= '0;
			mcount_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd == CMD_PUSH) begin
							done_q <= 1'b1;
							if (!full) begin
								vcount_q <= vcount_q + CW'(1);
								if (min_push) begin
									mcount_q <= mcount_q + CW'(1);
								end
							end
						end else if (vempty) begin
							done_q <= 1'b1;
						end else begin
							vcount_q <= vcount_pop;
							mcount_q <= mcount_pop;
							state_q  <= ST_WAIT;
						end
					end
				end
				ST_WAIT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Top-of-stack copies and the result registers carry no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_WAIT) begin
			vtop_q   <= v_rdata;
			mtop_q   <= m_rdata;
			min_q    <= mempty ? '0 : m_rdata;
			empty_q  <= vempty;
			status_q <= STATUS_OK;
		end else if (accept) begin
			if (cmd == CMD_PUSH) begin
				if (full) begin
					min_q    <= mempty ? '0 : mtop_q;
					empty_q  <= vempty;
					status_q <= STATUS_PUSH_FULL;
				end else begin
					vtop_q   <= value;
					if (min_push) begin
						mtop_q <= value;
					end
					min_q    <= min_push ? value : mtop_q;
					empty_q  <= 1'b0;
					status_q <= STATUS_OK;
				end
			end else if (vempty) begin
				min_q    <= '0;
				empty_q  <= 1'b1;
				status_q <= STATUS_POP_EMPTY;
			end
		end
	end

	assign done      = done_q;
	assign min_value = min_q;
	assign is_empty  = empty_q;
	assign status    = status_q;

endmodule

`default_nettype wire

[rtl/core/mts_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies; used for both stores of the minimum-tracking stack.
`default_nettype none

module mts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                     wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/core/mts_checker.sv]
// Port-level checker for the minimum-tracking stack, bound to the top level.
// Depends on mts_pkg and on the port list of min_tracking_stack.
`default_nettype none

module mts_checker #(
	parameter int DATA_WIDTH = 32
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         start,
	input wire logic                         busy,
	input wire logic                         cmd,
	input wire logic signed [DATA_WIDTH-1:0] value,
	input wire logic                         done,
	input wire logic signed [DATA_WIDTH-1:0] min_value,
	input wire logic                         is_empty,
	input wire mts_pkg::status_t             status
);

	import mts_pkg::*;

	// A push transfer always answers in the next cycle.
	a_push_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd == CMD_PUSH) |=> done)
		else $error("push result missing in the next cycle");

	// An empty stack reports a minimum of zero.
	a_empty_min: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_empty |-> (min_value == '0))
		else $error("empty stack with nonzero minimum");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STATUS_POP_EMPTY) |-> is_empty)
		else $error("ignored pop on a stack that is not empty");

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STATUS_PUSH_FULL) |-> !is_empty)
		else $error("ignored push on an empty stack");

	// After a successful push the minimum is no greater than the pushed value.
	a_push_min: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd == CMD_PUSH) ##1 (done && (status == STATUS_OK))
		|-> !is_empty && (min_value <= $past(value)))
		else $error("minimum above the value just pushed");

endmodule

bind min_tracking_stack mts_checker #(.DATA_WIDTH(DATA_WIDTH)) u_mts_checker (.*);

`default_nettype wire
